### rtl/scas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scas_pkg;
  localparam int MaxCols = 1024;
  localparam int MaxNnz = 16384;
  localparam int ColAw = $clog2(MaxCols + 1);
  localparam int NnzAw = $clog2(MaxNnz);
  localparam int PtrW = 15;
  localparam int RowW = 10;
  localparam int ValW = 32;

  localparam logic [2:0] CmdLoadPtr = 3'd0;
  localparam logic [2:0] CmdLoadEntry = 3'd1;
  localparam logic [2:0] CmdAdd = 3'd2;
  localparam logic [2:0] CmdGet = 3'd3;
  localparam logic [2:0] CmdZero = 3'd4;
  localparam logic [2:0] CmdScale = 3'd5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [14:0] slot;
    logic [14:0] pointer_value;
    logic [9:0] row;
    logic [9:0] col;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic status;
  } out_word_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [PtrW-1:0] clamp_nnz(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p > PtrW'(MaxNnz)) ? PtrW'(MaxNnz) : p;
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/scas_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface scas_in_if;
  import scas_pkg::*;
  logic valid;
  logic ready;
  in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface scas_out_if;
  import scas_pkg::*;
  logic valid;
  logic ready;
  out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface scas_cfg_if;
  logic valid;
  logic ready;
  logic [10:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/sparse_csc_accumulate_store_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Compressed-sparse-column matrix store with Q16.16 values.
// Input channel in_*: one command word (load pointer, load entry, add, get,
// zero, scale). Output channel out_*: exactly one result word per command,
// holding read_value (get only) and status (1 = not found or refused).
// Config channel cfg_*: num_cols, accepted only while no command is in flight.
// Loads and refused add or get give their result word once the command word
// is decoded. Add and get read the two column pointers, binary-search the
// column in the row memory one probe at a time through its single read port,
// then read the value and, for add, write back the saturated sum.
// Zero and scale read the entry count, then walk the stored entries one at a
// time through the value memory; scale passes each one through the multiplier
// pipeline before writing it back.
// One command is processed at a time; the next command word can be taken in
// the cycle after the result word has been taken. The result sits in an output
// register; while the receiver stalls, the next command is not taken.
// After reset num_cols is 1 and the stores are undefined until loaded.
module sparse_csc_accumulate_store_top (
  input wire logic clk,
  input wire logic rst_n,
  scas_in_if.sink in_ch,
  scas_out_if.source out_ch,
  scas_cfg_if.sink cfg_ch
);
  import scas_pkg::*;

  localparam logic [3:0] SIdle = 4'd0, SPtrA = 4'd1, SPtrB = 4'd2, SPtrC = 4'd3,
    SSrch = 4'd4, SCmp = 4'd5, SVal = 4'd6, SAddW = 4'd7, SWalkRd = 4'd8,
    SWalkM1 = 4'd9, SWalkM2 = 4'd10, SWalkW = 4'd11, SOut = 4'd12, SNnz = 4'd13,
    SNnzB = 4'd14;

  logic [3:0] st_r, st_nxt;
  in_word_t cmd_r;
  logic [10:0] ncols_r;
  logic [PtrW-1:0] lo_r, hi_r, start_r;
  logic [PtrW-1:0] mid;
  logic [PtrW-1:0] idx_r;
  out_word_t res_r;
  logic ovalid_r;

  logic cs_we, ri_we, ev_we;
  logic [ColAw-1:0] cs_waddr, cs_raddr;
  logic [PtrW-1:0] cs_wdata, cs_rdata;
  logic [NnzAw-1:0] ri_waddr, ri_raddr, ev_waddr, ev_raddr;
  logic [RowW-1:0] ri_rdata;
  logic [ValW-1:0] ev_wdata, ev_rdata;
  logic signed [31:0] mul_q;

  scas_ram #(.Width(PtrW), .Depth(MaxCols + 1)) u_cs (.clk, .we(cs_we),
    .waddr(cs_waddr), .wdata(cs_wdata), .raddr(cs_raddr), .rdata(cs_rdata));
  scas_ram #(.Width(RowW), .Depth(MaxNnz)) u_ri (.clk, .we(ri_we),
    .waddr(ri_waddr), .wdata(cmd_r.row), .raddr(ri_raddr), .rdata(ri_rdata));
  scas_ram #(.Width(ValW), .Depth(MaxNnz)) u_ev (.clk, .we(ev_we),
    .waddr(ev_waddr), .wdata(ev_wdata), .raddr(ev_raddr), .rdata(ev_rdata));
  scas_mul u_mul (.clk, .a(ev_rdata), .b(cmd_r.value), .q_r(mul_q));

  // lo/hi held one above their true values so hi never goes negative.
  assign mid = PtrW'(({1'b0, lo_r} + {1'b0, hi_r} - 16'd2) >> 1);

  assign in_ch.ready = (st_r == SIdle) && !ovalid_r;
  assign cfg_ch.ready = (st_r == SIdle) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = res_r;

  logic [ColAw-1:0] ncols_idx;
  assign ncols_idx = ColAw'(ncols_r);

  always_comb begin
    st_nxt = st_r;
    cs_we = 1'b0; ri_we = 1'b0; ev_we = 1'b0;
    cs_waddr = cmd_r.slot[ColAw-1:0];
    cs_wdata = cmd_r.pointer_value;
    cs_raddr = ColAw'(cmd_r.col);
    ri_waddr = cmd_r.slot[NnzAw-1:0];
    ri_raddr = mid[NnzAw-1:0];
    ev_waddr = idx_r[NnzAw-1:0];
    ev_raddr = idx_r[NnzAw-1:0];
    ev_wdata = cmd_r.value;
    case (st_r)
      SIdle: if (in_ch.valid && in_ch.ready) st_nxt = SPtrA;
      SPtrA: begin
        case (cmd_r.cmd)
          CmdLoadPtr: begin
            cs_we = cmd_r.slot <= PtrW'(MaxCols);
            st_nxt = SOut;
          end
          CmdLoadEntry: begin
            ri_we = cmd_r.slot < PtrW'(MaxNnz);
            ev_we = ri_we;
            ev_waddr = cmd_r.slot[NnzAw-1:0];
            st_nxt = SOut;
          end
          CmdAdd, CmdGet: begin
            cs_raddr = ColAw'(cmd_r.col);
            st_nxt = ({1'b0, cmd_r.col} >= ncols_r) ? SOut : SPtrB;
          end
          CmdZero, CmdScale: begin
            cs_raddr = ncols_idx;
            st_nxt = SNnz;
          end
          default: st_nxt = SOut;
        endcase
      end
      SPtrB: begin
        cs_raddr = ColAw'(cmd_r.col) + ColAw'(1);
        st_nxt = SPtrC;
      end
      SPtrC: st_nxt = SSrch;
      SSrch: st_nxt = (hi_r < lo_r || hi_r == '0) ? SOut : SCmp;
      SCmp: begin
        // Start the value read at the midpoint so it is ready on a hit.
        ev_raddr = mid[NnzAw-1:0];
        st_nxt = (cmd_r.row == ri_rdata) ? SVal : SSrch;
      end
      SVal: st_nxt = (cmd_r.cmd == CmdAdd) ? SAddW : SOut;
      SAddW: begin
        ev_we = 1'b1;
        ev_wdata = sat32(64'(signed'(ev_rdata)) + 64'(cmd_r.value));
        st_nxt = SOut;
      end
      SNnz: begin
        cs_raddr = ncols_idx;
        st_nxt = SNnzB;
      end
      SNnzB: st_nxt = SWalkRd;
      SWalkRd: begin
        if (idx_r >= hi_r) st_nxt = SOut;
        else if (cmd_r.cmd == CmdZero) begin
          ev_we = 1'b1;
          ev_wdata = '0;
        end else st_nxt = SWalkM1;
      end
      SWalkM1: st_nxt = SWalkM2;
      SWalkM2: st_nxt = SWalkW;
      SWalkW: begin
        ev_we = 1'b1;
        ev_wdata = mul_q;
        st_nxt = SWalkRd;
      end
      SOut: st_nxt = SIdle;
      default: st_nxt = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SIdle;
      ovalid_r <= 1'b0;
      ncols_r <= 11'd1;
    end else begin
      st_r <= st_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.data == '0) ncols_r <= 11'd1;
        else if (cfg_ch.data > 11'(MaxCols)) ncols_r <= 11'(MaxCols);
        else ncols_r <= cfg_ch.data;
      end
      if (st_r == SOut) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
    case (st_r)
      SIdle: if (in_ch.valid && in_ch.ready) begin
        cmd_r <= in_ch.data;
        res_r <= '0;
        idx_r <= '0;
      end
      SPtrA: begin
        if ((cmd_r.cmd == CmdLoadPtr && cmd_r.slot > PtrW'(MaxCols)) ||
            (cmd_r.cmd == CmdLoadEntry && cmd_r.slot >= PtrW'(MaxNnz)) ||
            ((cmd_r.cmd == CmdAdd || cmd_r.cmd == CmdGet) &&
             {1'b0, cmd_r.col} >= ncols_r))
          res_r.status <= 1'b1;
      end
      SPtrB: start_r <= clamp_nnz(cs_rdata);
      SPtrC: begin
        lo_r <= start_r + PtrW'(1);
        hi_r <= clamp_nnz(cs_rdata);
      end
      SSrch: if (hi_r < lo_r || hi_r == '0) res_r.status <= 1'b1;
      SCmp: begin
        if (cmd_r.row < ri_rdata) hi_r <= mid;
        else if (cmd_r.row > ri_rdata) lo_r <= mid + PtrW'(2);
        else idx_r <= mid;
      end
      SVal: if (cmd_r.cmd == CmdGet) res_r.read_value <= ev_rdata;
      SNnzB: hi_r <= clamp_nnz(cs_rdata);
      SWalkRd: if (cmd_r.cmd == CmdZero) idx_r <= idx_r + PtrW'(1);
      SWalkW: idx_r <= idx_r + PtrW'(1);
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/scas_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module scas_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/scas_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// Q16.16 multiply: product registered, then rounded and saturated into the output register.
module scas_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [31:0]      q_r
);
  import scas_pkg::*;
  logic signed [63:0] prod_r;
  logic signed [63:0] rnd;
  always_comb rnd = (prod_r + 64'sd32768) >>> 16;
  always_ff @(posedge clk) begin
    prod_r <= a * b;
    q_r <= sat32(rnd);
  end
endmodule
`default_nettype wire
